// ----- design/mifc_pkg.sv -----
package mifc_pkg;

	localparam int BANK_COUNT = 4;
	localparam int BANK_WIDTH = 32;

	// function codes of an input beat
	localparam logic [2:0] FN_READ       = 3'd0;
	localparam logic [2:0] FN_WRITE      = 3'd1;
	localparam logic [2:0] FN_READ_SET   = 3'd2;
	localparam logic [2:0] FN_READ_CLEAR = 3'd3;
	localparam logic [2:0] FN_RAISE      = 3'd4;
	localparam logic [2:0] FN_CLAIM      = 3'd5;
	localparam logic [2:0] FN_COMPLETE   = 3'd6;
	localparam logic [2:0] FN_READ_SAVED = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [1:0]  bank;
		logic        is_mask;
		logic [31:0] write_data;
		logic [6:0]  line;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        line_enabled;
		logic [7:0]  claimed_line;
		logic        spurious;
		logic        irq_out;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;       // capture the input beat
		logic       exec;       // apply a non-claim function
		logic       scan;       // test one bank for a pending line
		logic       scan_last;  // bank under test is the last implemented one
		logic [1:0] scan_bank;
		logic       finish;     // load the output register
	} mifc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_claim;
		logic bank_hit;
	} mifc_status_t;

endpackage

// ----- design/mifc_ctrl.sv -----
module mifc_ctrl #(
	parameter int NUM_LINES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  mifc_pkg::mifc_status_t status,
	output mifc_pkg::mifc_cmd_t    cmd
);
	import mifc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [1:0] LastBank = 2'((NUM_LINES - 1) / BANK_WIDTH);

	logic [1:0] state_q, state_d;
	logic [1:0] scan_q, scan_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		scan_d  = scan_q;
		cmd     = '0;
		cmd.scan_bank = scan_q;
		cmd.scan_last = (scan_q == LastBank);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_claim) begin
					scan_d  = '0;
					state_d = ST_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.bank_hit || cmd.scan_last) begin
					state_d = ST_FIN;
				end else begin
					scan_d = scan_q + 2'd1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/mifc_datapath.sv -----
module mifc_datapath #(
	parameter int NUM_LINES = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mifc_pkg::in_item_t     in_data,
	input  mifc_pkg::mifc_cmd_t    cmd,
	output mifc_pkg::mifc_status_t status,
	output mifc_pkg::out_item_t    out_data
);
	import mifc_pkg::*;

	function automatic logic [BANK_COUNT-1:0][BANK_WIDTH-1:0] build_valid();
		logic [BANK_COUNT-1:0][BANK_WIDTH-1:0] v;
		int lo;
		for (int b = 0; b < BANK_COUNT; b++) begin
			lo = BANK_WIDTH * b;
			if (NUM_LINES >= lo + BANK_WIDTH) begin
				v[b] = '1;
			end else if (NUM_LINES <= lo) begin
				v[b] = '0;
			end else begin
				v[b] = (32'd1 << (NUM_LINES - lo)) - 32'd1;
			end
		end
		return v;
	endfunction

	localparam logic [BANK_COUNT-1:0][BANK_WIDTH-1:0] BankValid = build_valid();
	localparam logic [7:0] NumLines = 8'(NUM_LINES);

	in_item_t    req_q;
	logic [BANK_COUNT-1:0][BANK_WIDTH-1:0] flag_q, mask_q;
	logic [7:0]  saved_q;
	logic [31:0] res_rd_q;
	logic [7:0]  res_claim_q;
	logic        res_spur_q;
	out_item_t   out_q;

	logic [31:0] cur, valid, pend, lsb;
	logic [4:0]  enc;
	logic [BANK_COUNT-1:0][BANK_WIDTH-1:0] live;
	logic        line_ok, saved_ok;

	always_comb begin
		valid    = BankValid[req_q.bank];
		cur      = req_q.is_mask ? mask_q[req_q.bank] : flag_q[req_q.bank];
		pend     = flag_q[cmd.scan_bank] & mask_q[cmd.scan_bank] & BankValid[cmd.scan_bank];
		// isolate the lowest set bit, then encode the one-hot word
		lsb      = pend & (~pend + 32'd1);
		for (int k = 0; k < 5; k++) begin
			enc[k] = 1'b0;
			for (int i = 0; i < BANK_WIDTH; i++) begin
				if (((i >> k) & 1) == 1) begin
					enc[k] = enc[k] | lsb[i];
				end
			end
		end
		for (int b = 0; b < BANK_COUNT; b++) begin
			live[b] = flag_q[b] & mask_q[b] & BankValid[b];
		end
		line_ok  = ({1'b0, req_q.line} < NumLines);
		saved_ok = (saved_q < NumLines);
	end

	assign status.is_claim = (req_q.func == FN_CLAIM);
	assign status.bank_hit = |pend;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= '0;
			mask_q  <= '0;
			saved_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (req_q.func)
					FN_WRITE: begin
						if (req_q.is_mask) mask_q[req_q.bank] <= req_q.write_data & valid;
						else flag_q[req_q.bank] <= req_q.write_data & valid;
					end
					FN_READ_SET: begin
						if (req_q.is_mask) mask_q[req_q.bank] <= (cur | req_q.write_data) & valid;
						else flag_q[req_q.bank] <= (cur | req_q.write_data) & valid;
					end
					FN_READ_CLEAR: begin
						if (req_q.is_mask) mask_q[req_q.bank] <= cur & ~req_q.write_data & valid;
						else flag_q[req_q.bank] <= cur & ~req_q.write_data & valid;
					end
					FN_RAISE: begin
						if (line_ok) flag_q[req_q.line[6:5]][req_q.line[4:0]] <= 1'b1;
					end
					FN_COMPLETE: begin
						if (saved_ok) flag_q[saved_q[6:5]][saved_q[4:0]] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.scan) begin
				if (status.bank_hit) begin
					saved_q <= {1'b0, cmd.scan_bank, enc};
				end else if (cmd.scan_last) begin
					saved_q <= NumLines;
				end
			end
		end
	end

	// result of the beat under way
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_rd_q    <= '0;
			res_claim_q <= '0;
			res_spur_q  <= 1'b0;
		end
		if (cmd.exec) begin
			case (req_q.func)
				FN_READ, FN_WRITE, FN_READ_SET, FN_READ_CLEAR: res_rd_q <= cur & valid;
				FN_READ_SAVED: res_claim_q <= saved_q;
				default: ;
			endcase
		end
		if (cmd.scan) begin
			if (status.bank_hit) begin
				res_claim_q <= {1'b0, cmd.scan_bank, enc};
				res_spur_q  <= 1'b0;
			end else if (cmd.scan_last) begin
				res_claim_q <= NumLines;
				res_spur_q  <= 1'b1;
			end
		end
		if (cmd.finish) begin
			out_q.read_data    <= res_rd_q;
			out_q.line_enabled <= line_ok & mask_q[req_q.line[6:5]][req_q.line[4:0]];
			out_q.claimed_line <= res_claim_q;
			out_q.spurious     <= res_spur_q;
			out_q.irq_out      <= |live;
		end
	end

	assign out_data = out_q;

endmodule

// ----- design/masked_interrupt_flag_controller_top.sv -----
// Interrupt flag and mask controller with up to 128 lines in four 32-bit
// banks, lowest-numbered line wins. Each input beat is one function: a
// read, write, read-set or read-clear of a flag or mask bank (old value
// returned), a raise of one line, a claim (finds and saves the lowest
// pending enabled line, or NUM_LINES with spurious set), a complete (clears
// the saved line's flag) or a read of the saved line. Every beat returns
// one result beat carrying the mask bit of the given line and the irq
// level after the update. One beat is worked at a time by a small
// sequencer: a beat passes an accept state and an execute state,
// and a claim then a scan state that visits k (1..4) banks, one 32-bit
// bank per cycle, stopping at the first bank with a pending line. A
// finish state then loads the output register and reopens the input
// at the same edge. A finished result waits in the sequencer while the
// output register still holds a stalled beat. The output register lets
// a new beat be accepted while the previous result is still stalled.
module masked_interrupt_flag_controller_top #(
	parameter int NUM_LINES = 128  // 32..128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mifc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mifc_pkg::out_item_t out_data
);
	import mifc_pkg::*;

	mifc_cmd_t    cmd;
	mifc_status_t status;

	// sequencer: accept, execute or scan, then hand the result over
	mifc_ctrl #(
		.NUM_LINES(NUM_LINES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// flag/mask banks, saved line, bank scanner and output register
	mifc_datapath #(
		.NUM_LINES(NUM_LINES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (status),
		.out_data(out_data)
	);

	// one beat at a time: an accepted beat closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accept");

	// a result only appears while a beat is being worked
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a beat in work");

	// a spurious claim reports the line count
	a_spurious_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.spurious |-> out_data.claimed_line == 8'(NUM_LINES))
		else $error("spurious claim with a real line");

	// nothing pending means no irq
	a_spurious_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.spurious |-> !out_data.irq_out)
		else $error("irq with a spurious claim");

endmodule

// ----- test/mifc_result_checker.sv -----
module mifc_result_checker #(
	parameter int NUM_LINES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  mifc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  mifc_pkg::out_item_t out_data,
	output int                  errors,
	output int                  due_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import mifc_pkg::*;

	logic [31:0] flags [BANK_COUNT];
	logic [31:0] masks [BANK_COUNT];
	logic [7:0]  saved;
	out_item_t   due_results [$];
	int          err_cnt;

	assign errors = err_cnt;

	// implemented bits of one bank
	function automatic logic [31:0] bank_bits(int bank);
		int lo;
		lo = 32 * bank;
		if (NUM_LINES >= lo + 32)
			return '1;
		if (NUM_LINES <= lo)
			return '0;
		return (32'd1 << (NUM_LINES - lo)) - 32'd1;
	endfunction

	function automatic logic [7:0] lowest_pending();
		logic [31:0] hits;
		for (int b = 0; b < BANK_COUNT; b++) begin
			hits = flags[b] & masks[b] & bank_bits(b);
			for (int i = 0; i < 32; i++)
				if (hits[i])
					return 8'(32 * b + i);
		end
		return 8'(NUM_LINES);
	endfunction

	// applies one beat to the flag/mask state and returns its result
	function automatic out_item_t step_flags_masks(in_item_t beat);
		out_item_t   res;
		logic [31:0] valid;
		logic [31:0] old;
		logic [31:0] upd;
		res = '0;
		valid = bank_bits(beat.bank);
		old = (beat.is_mask ? masks[beat.bank] : flags[beat.bank]) & valid;
		upd = old;
		case (beat.func)
		FN_READ: res.read_data = old;
		FN_WRITE, FN_READ_SET, FN_READ_CLEAR: begin
			res.read_data = old;
			if (beat.func == FN_WRITE)
				upd = beat.write_data & valid;
			else if (beat.func == FN_READ_SET)
				upd = (old | beat.write_data) & valid;
			else
				upd = old & ~beat.write_data & valid;
			if (beat.is_mask)
				masks[beat.bank] = upd;
			else
				flags[beat.bank] = upd;
		end
		FN_RAISE: begin
			if (beat.line < NUM_LINES)
				flags[beat.line[6:5]][beat.line[4:0]] = 1'b1;
		end
		FN_CLAIM: begin
			res.claimed_line = lowest_pending();
			res.spurious = (res.claimed_line >= NUM_LINES);
			saved = res.claimed_line;
		end
		FN_COMPLETE: begin
			if (saved < NUM_LINES)
				flags[saved[6:5]][saved[4:0]] = 1'b0;
		end
		FN_READ_SAVED: res.claimed_line = saved;
		endcase
		if (beat.line < NUM_LINES)
			res.line_enabled = masks[beat.line[6:5]][beat.line[4:0]];
		for (int b = 0; b < BANK_COUNT; b++)
			if ((flags[b] & masks[b] & bank_bits(b)) != '0)
				res.irq_out = 1'b1;
		return res;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int b = 0; b < BANK_COUNT; b++) begin
				flags[b] = '0;
				masks[b] = '0;
			end
			saved = '0;
			due_results.delete();
			due_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				due_results.push_back(step_flags_masks(in_data));
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h",
						$time, out_data);
					err_cnt++;
				end else begin
					want = due_results.pop_front();
					check_field("read_data", want.read_data, out_data.read_data);
					check_field("line_enabled", want.line_enabled, out_data.line_enabled);
					check_field("claimed_line", want.claimed_line, out_data.claimed_line);
					check_field("spurious", want.spurious, out_data.spurious);
					check_field("irq_out", want.irq_out, out_data.irq_out);
				end
			end
			due_count <= due_results.size();
		end
	end

endmodule

// ----- test/tb_masked_interrupt_flag_controller_top.sv -----
module tb_masked_interrupt_flag_controller_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mifc_pkg::*;

	localparam int NUM_LINES = 128;

	// register access codes, picked at random for access beats
	localparam logic [2:0] ACCESS_FNS [4] = '{FN_READ, FN_WRITE, FN_READ_SET, FN_READ_CLEAR};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	// idle chances in percent per cycle; hold_phase asks the receiver for one long hold-off
	int send_idle;
	int recv_idle;
	bit hold_phase;

	int errors;
	int due_count;
	int sent;

	always #10 clk = ~clk;

	masked_interrupt_flag_controller_top #(.NUM_LINES(NUM_LINES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// watches both channels, predicts every result beat and compares
	mifc_result_checker #(.NUM_LINES(NUM_LINES)) watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (errors),
		.due_count (due_count)
	);

	// Hard stop. A correct run needs well under a millisecond even with
	// the heaviest idling; this leaves a wide margin.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver side: random stall per cycle, plus one hold-off
	// once the pressure phase starts. The sender keeps offering beats
	// during the hold-off, so the output register and the sequencer fill
	// up and in_stall has to rise.
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_phase && !held) begin
				held = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	function automatic in_item_t beat_of(logic [2:0] fn, logic [1:0] bank, logic is_mask,
		logic [31:0] wdata, logic [6:0] line);
		in_item_t beat;
		beat.func = fn;
		beat.bank = bank;
		beat.is_mask = is_mask;
		beat.write_data = wdata;
		beat.line = line;
		return beat;
	endfunction

	// mostly the interesting patterns: all clear, all set, one bit
	function automatic logic [31:0] rand_pattern();
		case ($urandom_range(3))
		0: return '0;
		1: return '1;
		2: return 32'd1 << $urandom_range(31);
		default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t rand_beat();
		in_item_t    beat;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			beat.func = ACCESS_FNS[$urandom_range(3)];
		else if (pick < 65)
			beat.func = FN_RAISE;
		else if (pick < 80)
			beat.func = FN_CLAIM;
		else if (pick < 92)
			beat.func = FN_COMPLETE;
		else
			beat.func = FN_READ_SAVED;
		beat.bank = 2'($urandom());
		beat.is_mask = 1'($urandom());
		beat.write_data = rand_pattern();
		beat.line = 7'($urandom());
		return beat;
	endfunction

	// Offers one beat and returns right after the edge that took it.
	// Exactly one assignment to in_valid per edge: either the next beat
	// keeps it high or the idle loop drops it.
	task automatic send_beat(in_item_t beat);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Random traffic. About 40% of the time a full service sequence:
	// raise a few lines, claim, maybe read back the saved line, complete.
	// The rest are single random beats that also keep reprogramming the
	// flag and mask banks.
	task automatic run_random(int count);
		int stop;
		stop = sent + count;
		while (sent < stop) begin
			if ($urandom_range(99) < 40) begin
				repeat ($urandom_range(1, 3))
					send_beat(beat_of(FN_RAISE, 2'($urandom()), 1'($urandom()), $urandom(),
						7'($urandom())));
				send_beat(beat_of(FN_CLAIM, 2'($urandom()), 1'($urandom()), $urandom(),
					7'($urandom())));
				if ($urandom_range(1))
					send_beat(beat_of(FN_READ_SAVED, 2'($urandom()), 1'($urandom()),
						$urandom(), 7'($urandom())));
				send_beat(beat_of(FN_COMPLETE, 2'($urandom()), 1'($urandom()), $urandom(),
					7'($urandom())));
			end else begin
				send_beat(rand_beat());
			end
		end
	endtask

	initial begin
		send_idle = 6;
		recv_idle = 74;
		hold_phase = 1'b0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, complete before any claim (hits line 0),
		// claim order within a bank, top line, spurious claim, complete
		// after a spurious claim, set/clear patterns at both extremes
		send_beat(beat_of(FN_READ, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_READ, 2'd3, 1'b1, '1, 7'd127));
		send_beat(beat_of(FN_RAISE, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_RAISE, 2'd3, 1'b1, '1, 7'd127));
		send_beat(beat_of(FN_COMPLETE, 2'd2, 1'b0, 32'h5555_5555, 7'h55));
		send_beat(beat_of(FN_READ, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_WRITE, 2'd0, 1'b0, '1, 7'd0));
		send_beat(beat_of(FN_WRITE, 2'd0, 1'b1, 32'h8000_0001, 7'd31));
		send_beat(beat_of(FN_CLAIM, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_READ_SAVED, 2'd1, 1'b1, '1, 7'd1));
		send_beat(beat_of(FN_COMPLETE, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_CLAIM, 2'd0, 1'b0, '0, 7'd31));
		send_beat(beat_of(FN_COMPLETE, 2'd0, 1'b0, '0, 7'd31));
		send_beat(beat_of(FN_WRITE, 2'd3, 1'b1, '1, 7'd127));
		send_beat(beat_of(FN_CLAIM, 2'd3, 1'b0, '0, 7'd127));
		send_beat(beat_of(FN_READ_SET, 2'd1, 1'b0, 32'hAAAA_AAAA, 7'd64));
		send_beat(beat_of(FN_READ_SET, 2'd1, 1'b1, 32'h0002_0000, 7'd49));
		send_beat(beat_of(FN_CLAIM, 2'd1, 1'b0, '0, 7'd49));
		send_beat(beat_of(FN_READ_CLEAR, 2'd1, 1'b0, '1, 7'd64));
		send_beat(beat_of(FN_READ_CLEAR, 2'd3, 1'b0, '1, 7'd127));
		send_beat(beat_of(FN_WRITE, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_CLAIM, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_COMPLETE, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_READ_SAVED, 2'd0, 1'b0, '0, 7'd0));
		send_beat(beat_of(FN_READ_CLEAR, 2'd0, 1'b1, '1, 7'd0));
		send_beat(beat_of(FN_READ, 2'd2, 1'b1, '0, 7'd100));

		// phase 1: busy sender, slow receiver
		run_random(170);

		// phase 2: sparse sender, fast receiver
		send_idle = 74;
		recv_idle <= 6;
		run_random(170);

		// phase 3: no idling either side, with the long hold-off up front
		send_idle = 0;
		recv_idle <= 0;
		hold_phase <= 1'b1;
		run_random(160);

		// drain: let due_count catch up with the last accepted beat, then
		// wait out the outstanding results and then watch for strays
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/mifc_pkg.sv
design/mifc_ctrl.sv
design/mifc_datapath.sv
design/masked_interrupt_flag_controller_top.sv
test/mifc_result_checker.sv
test/tb_masked_interrupt_flag_controller_top.sv
